// File: design/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared codes, register defaults and types for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	// operation codes carried with each input beat
	localparam logic [1:0] OP_POLL    = 2'd0;
	localparam logic [1:0] OP_CONSUME = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// configuration register indexes
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ENC_WINDOW   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TOP_WINDOW   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_DELAY = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_IVAL  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROTARY_EN    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SIDE_EN      = 3'd5;

	// register reset values
	localparam logic [15:0] ENC_WINDOW_RST   = 16'd300;
	localparam logic [15:0] TOP_WINDOW_RST   = 16'd300;
	localparam logic [15:0] REPEAT_DELAY_RST = 16'd400;
	localparam logic [15:0] REPEAT_IVAL_RST  = 16'd100;
	localparam logic        ROTARY_EN_RST    = 1'b1;
	localparam logic        SIDE_EN_RST      = 1'b0;

	// outcome of one click classifier pass
	typedef struct packed {
		logic pending;     // next pending flag
		logic load_time;   // capture now as click time
		logic expired;     // pending click timed out into a single click
		logic dbl;         // double click seen
		logic ignore_clr;  // ignore flag consumed by this click
	} click_res_t;

	// outcome of one side button repeat pass
	typedef struct packed {
		logic        fire;  // one step this poll
		logic [31:0] due;   // next due time, zero is idle
	} repeat_res_t;

endpackage

// File: design/button_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_top
// Poll-driven encoder delta, side button auto-repeat and click gesture
// classification for an encoder button and a top button.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  poll     | poll_valid, poll_stall | op, now_ms, encoder_position, flags
//  result   | res_valid, res_stall   | steps, encoder_events, top_events, ...
//  config   | wr_en                  | wr_index, wr_data
//
//  One beat per cycle while the result side does not stall: an accepted beat
//  is held in the input register, and its work is done as it moves on into
//  the result register, where res_valid rises and the result can be taken.
//  Consume and clear beats update state
//  and give no result. Reset is asynchronous and clears all state and the
//  registers to their defaults. A stall on the result side holds the result
//  register and, once the input register is also full, stalls the poll side.
//
module button_gesture_classifier_top (
	input  logic               clk,
	input  logic               arst_n,
	// config write port
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data,
	// poll channel
	input  logic               poll_valid,
	output logic               poll_stall,
	input  logic [1:0]         op,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] encoder_position,
	input  logic [3:0]         encoder_flags,
	input  logic [3:0]         top_flags,
	input  logic [1:0]         side_down_flags,
	input  logic [1:0]         side_up_flags,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [15:0] steps,
	output logic [5:0]         encoder_events,
	output logic [4:0]         top_events,
	output logic               any_held,
	output logic               touched
);

	// configuration registers
	logic [15:0] enc_window_q;
	logic [15:0] top_window_q;
	logic [15:0] repeat_delay_q;
	logic [15:0] repeat_ival_q;
	logic        rotary_en_q;
	logic        side_en_q;

	// classifier state
	logic [15:0] last_pos_q;
	logic        last_enc_pressed_q;
	logic        enc_pending_q;
	logic [31:0] enc_time_q;
	logic        top_pending_q;
	logic [31:0] top_time_q;
	logic        ignore_top_q;
	logic [31:0] down_due_q;
	logic [31:0] up_due_q;

	// input register
	logic        s1_valid_q;
	logic [1:0]  op_s1;
	logic [31:0] now_s1;
	logic [15:0] pos_s1;
	logic [3:0]  ef_s1;
	logic [3:0]  tf_s1;
	logic [1:0]  df_s1;
	logic [1:0]  uf_s1;

	// result register
	logic        res_valid_q;
	logic [15:0] steps_q;
	logic [5:0]  enc_ev_q;
	logic [4:0]  top_ev_q;
	logic        held_q;
	logic        touched_q;

	logic poll_acc;
	logic s1_adv;
	logic is_poll;

	bgc_pkg::click_res_t  enc_res;
	bgc_pkg::click_res_t  top_res;
	bgc_pkg::repeat_res_t down_res;
	bgc_pkg::repeat_res_t up_res;

	logic [15:0] pos_delta;
	logic [15:0] side_sum;
	logic [15:0] steps_d;
	logic [5:0]  enc_ev_d;
	logic [4:0]  top_ev_d;
	logic        held_d;
	logic        touched_d;

	// handshake control
	assign s1_adv     = s1_valid_q && (!res_valid_q || !res_stall);
	assign poll_stall = s1_valid_q && res_valid_q && res_stall;
	assign poll_acc   = poll_valid && !poll_stall;
	assign is_poll    = (op_s1 == bgc_pkg::OP_POLL);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_window_q   <= bgc_pkg::ENC_WINDOW_RST;
			top_window_q   <= bgc_pkg::TOP_WINDOW_RST;
			repeat_delay_q <= bgc_pkg::REPEAT_DELAY_RST;
			repeat_ival_q  <= bgc_pkg::REPEAT_IVAL_RST;
			rotary_en_q    <= bgc_pkg::ROTARY_EN_RST;
			side_en_q      <= bgc_pkg::SIDE_EN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				bgc_pkg::REG_ENC_WINDOW:   enc_window_q   <= wr_data;
				bgc_pkg::REG_TOP_WINDOW:   top_window_q   <= wr_data;
				bgc_pkg::REG_REPEAT_DELAY: repeat_delay_q <= wr_data;
				bgc_pkg::REG_REPEAT_IVAL:  repeat_ival_q  <= wr_data;
				bgc_pkg::REG_ROTARY_EN:    rotary_en_q    <= wr_data[0];
				bgc_pkg::REG_SIDE_EN:      side_en_q      <= wr_data[0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (poll_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (poll_acc) begin
			op_s1  <= op;
			now_s1 <= now_ms;
			pos_s1 <= encoder_position;
			ef_s1  <= encoder_flags;
			tf_s1  <= top_flags;
			df_s1  <= side_down_flags;
			uf_s1  <= side_up_flags;
		end
	end

	// click classifiers
	bgc_click u_enc_click (
		.pending    (enc_pending_q),
		.click_time (enc_time_q),
		.window     (enc_window_q),
		.now_ms     (now_s1),
		.click      (ef_s1[2]),
		.long_click (ef_s1[3]),
		.ignore     (1'b0),
		.res        (enc_res)
	);

	bgc_click u_top_click (
		.pending    (top_pending_q),
		.click_time (top_time_q),
		.window     (top_window_q),
		.now_ms     (now_s1),
		.click      (tf_s1[2]),
		.long_click (tf_s1[3]),
		.ignore     (ignore_top_q),
		.res        (top_res)
	);

	// side button repeat
	bgc_repeat u_down_rep (
		.flags         (df_s1),
		.due_q         (down_due_q),
		.now_ms        (now_s1),
		.initial_delay (repeat_delay_q),
		.interval      (repeat_ival_q),
		.res           (down_res)
	);

	bgc_repeat u_up_rep (
		.flags         (uf_s1),
		.due_q         (up_due_q),
		.now_ms        (now_s1),
		.initial_delay (repeat_delay_q),
		.interval      (repeat_ival_q),
		.res           (up_res)
	);

	// step count and event bits
	always_comb begin
		pos_delta = rotary_en_q ? (last_pos_q - pos_s1) : 16'd0;
		side_sum  = 16'd0;
		if (side_en_q) begin
			side_sum = {16{down_res.fire}} + {15'd0, up_res.fire};
		end
		steps_d  = pos_delta + side_sum;
		enc_ev_d = {ef_s1[3], enc_res.dbl, enc_res.expired, ef_s1[0],
			last_enc_pressed_q && !ef_s1[0], ef_s1[1]};
		top_ev_d = {tf_s1[0], tf_s1[3], top_res.dbl, top_res.expired, tf_s1[1]};
		held_d   = ef_s1[0] || tf_s1[0] || (side_en_q && (df_s1[0] || uf_s1[0]));
		touched_d = (steps_d != '0) || (enc_ev_d != '0) || (top_ev_d[3:0] != '0)
			|| held_d;
	end

	// state update per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q         <= '0;
			last_enc_pressed_q <= 1'b0;
			enc_pending_q      <= 1'b0;
			enc_time_q         <= '0;
			top_pending_q      <= 1'b0;
			top_time_q         <= '0;
			ignore_top_q       <= 1'b0;
			down_due_q         <= '0;
			up_due_q           <= '0;
		end else if (s1_adv) begin
			unique case (op_s1)
				bgc_pkg::OP_POLL: begin
					if (rotary_en_q) begin
						last_pos_q <= pos_s1;
					end
					if (side_en_q) begin
						down_due_q <= down_res.due;
						up_due_q   <= up_res.due;
					end
					last_enc_pressed_q <= ef_s1[0];
					enc_pending_q      <= enc_res.pending;
					if (enc_res.load_time) begin
						enc_time_q <= now_s1;
					end
					top_pending_q <= top_res.pending;
					if (top_res.load_time) begin
						top_time_q <= now_s1;
					end
					if (top_res.ignore_clr) begin
						ignore_top_q <= 1'b0;
					end
				end
				bgc_pkg::OP_CONSUME: begin
					ignore_top_q  <= 1'b1;
					top_pending_q <= 1'b0;
				end
				bgc_pkg::OP_CLEAR: begin
					ignore_top_q  <= 1'b0;
					top_pending_q <= 1'b0;
					enc_pending_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= is_poll;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_adv && is_poll) begin
			steps_q   <= steps_d;
			enc_ev_q  <= enc_ev_d;
			top_ev_q  <= top_ev_d;
			held_q    <= held_d;
			touched_q <= touched_d;
		end
	end

	assign res_valid      = res_valid_q;
	assign steps          = steps_q;
	assign encoder_events = enc_ev_q;
	assign top_events     = top_ev_q;
	assign any_held       = held_q;
	assign touched        = touched_q;

	// poll side only stalls with a full input register
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		poll_stall |-> s1_valid_q)
		else $error("poll stall without a held beat");

	// non-poll beats never produce a result
	a_no_result_for_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !is_poll) |=> !res_valid_q)
		else $error("result from a consume or clear beat");

	// clear op drops every pending flag
	a_clear_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (op_s1 == bgc_pkg::OP_CLEAR))
		|=> (!ignore_top_q && !top_pending_q && !enc_pending_q))
		else $error("clear left a pending flag");

	// consume op arms the ignore flag
	a_consume_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (op_s1 == bgc_pkg::OP_CONSUME)) |=> (ignore_top_q && !top_pending_q))
		else $error("consume did not arm the ignore flag");

endmodule

// File: design/bgc_click.sv
// ----------------------------------------------------------------------------
// bgc_click
// Single versus double click separation within a time window, with long
// click cancel and an optional ignore flag.
// ----------------------------------------------------------------------------
module bgc_click (
	input  logic                 pending,
	input  logic [31:0]          click_time,
	input  logic [15:0]          window,
	input  logic [31:0]          now_ms,
	input  logic                 click,
	input  logic                 long_click,
	input  logic                 ignore,
	output bgc_pkg::click_res_t  res
);

	logic [31:0] age;
	logic        expired;
	logic        pend_after;

	// age of the pending click, wrapping
	assign age        = now_ms - click_time;
	assign expired    = pending && (age > {16'd0, window});
	assign pend_after = pending && !expired;

	// click decision
	always_comb begin
		res            = '0;
		res.expired    = expired;
		res.pending    = pend_after;
		if (click) begin
			if (ignore) begin
				res.ignore_clr = 1'b1;
				res.pending    = 1'b0;
			end else if (pend_after) begin
				res.dbl     = 1'b1;
				res.pending = 1'b0;
			end else begin
				res.pending   = 1'b1;
				res.load_time = 1'b1;
			end
		end
		if (long_click) begin
			res.pending = 1'b0;
		end
	end

endmodule

// File: design/bgc_repeat.sv
// ----------------------------------------------------------------------------
// bgc_repeat
// Side button step with initial delay and interval auto-repeat.
// ----------------------------------------------------------------------------
module bgc_repeat (
	input  logic [1:0]            flags,
	input  logic [31:0]           due_q,
	input  logic [31:0]           now_ms,
	input  logic [15:0]           initial_delay,
	input  logic [15:0]           interval,
	output bgc_pkg::repeat_res_t  res
);

	logic [31:0] late;

	// signed lateness against the due time
	assign late = now_ms - due_q;

	always_comb begin
		res.fire = 1'b0;
		res.due  = due_q;
		priority if (flags[1]) begin
			// press edge wins over the pressed bit
			res.fire = 1'b1;
			res.due  = now_ms + {16'd0, initial_delay};
		end else if (!flags[0]) begin
			res.due = '0;
		end else if ((due_q != '0) && !late[31]) begin
			res.fire = 1'b1;
			res.due  = now_ms + {16'd0, interval};
		end else begin
			// held, not yet due or idle: keep the due time
			res.due = due_q;
		end
	end

endmodule

// File: verif/button_gesture_classifier_top_tb.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_top_tb
// Self-checking bench for the button gesture classifier. Poll beats are
// driven with random gaps and the result side is stalled at random. An
// in-bench predictor keeps its own copy of the classifier state and
// registers, and each result beat is compared field by field with the
// oldest prediction. Directed beats cover field extremes, every op and the
// corner cases, then random phases run button press sequences under
// several register settings.
// ----------------------------------------------------------------------------
module button_gesture_classifier_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// op code the block ignores
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned PHASE_BEATS = 325;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now;
		logic [15:0] pos;
		logic [3:0]  enc_fl;
		logic [3:0]  top_fl;
		logic [1:0]  down_fl;
		logic [1:0]  up_fl;
	} poll_beat_t;

	typedef struct packed {
		logic signed [15:0] steps;
		logic [5:0]         enc_ev;
		logic [4:0]         top_ev;
		logic               held;
		logic               touched;
	} gesture_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [2:0]         wr_index;
	logic [15:0]        wr_data;
	logic               poll_valid;
	logic               poll_stall;
	logic [1:0]         op;
	logic [31:0]        now_ms;
	logic signed [15:0] encoder_position;
	logic [3:0]         encoder_flags;
	logic [3:0]         top_flags;
	logic [1:0]         side_down_flags;
	logic [1:0]         side_up_flags;
	logic               res_valid;
	logic               res_stall;
	logic signed [15:0] steps;
	logic [5:0]         encoder_events;
	logic [4:0]         top_events;
	logic               any_held;
	logic               touched;

	// predictor registers
	logic [15:0] enc_window, top_window, rpt_delay, rpt_ival;
	logic        rotary_en, side_en;

	// predictor state
	logic [15:0] last_pos;
	logic        enc_was_pressed;
	logic        enc_click_pend, top_click_pend, top_ignore;
	logic [31:0] enc_click_ms, top_click_ms;
	logic [31:0] down_due, up_due;

	gesture_t    awaited[$];
	int unsigned mismatches;
	int unsigned cycle_cnt;
	logic        quiet;

	// random gesture generator state
	logic [31:0]        sim_now;
	logic signed [15:0] sim_pos;
	logic               enc_down, top_down, dn_down, up_down;
	logic [31:0]        enc_since, top_since;

	button_gesture_classifier_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// side button step with auto-repeat, zero due means idle
	function automatic logic repeat_fires(input logic [1:0] fl, input logic [31:0] now,
			inout logic [31:0] due);
		logic [31:0] lag;
		lag = now - due;
		if (fl[1]) begin
			due = now + {16'd0, rpt_delay};
			return 1'b1;
		end
		if (!fl[0]) begin
			due = '0;
			return 1'b0;
		end
		if (due != '0 && !lag[31]) begin
			due = now + {16'd0, rpt_ival};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// classify one beat, returns whether a result beat follows
	function automatic logic forecast_gesture(input poll_beat_t b, output gesture_t g);
		logic [15:0] delta;
		logic        side_held;
		logic [31:0] age;
		logic [5:0]  ev;
		logic [4:0]  tv;
		logic        held;
		delta = '0;
		side_held = 1'b0;
		ev = '0;
		tv = '0;
		g = '0;
		if (b.op == bgc_pkg::OP_CONSUME) begin
			top_ignore = 1'b1;
			top_click_pend = 1'b0;
			return 1'b0;
		end
		if (b.op == bgc_pkg::OP_CLEAR) begin
			top_click_pend = 1'b0;
			top_ignore = 1'b0;
			enc_click_pend = 1'b0;
			return 1'b0;
		end
		if (b.op != bgc_pkg::OP_POLL)
			return 1'b0;

		// position delta and side steps
		if (rotary_en) begin
			delta = last_pos - b.pos;
			last_pos = b.pos;
		end
		if (side_en) begin
			if (repeat_fires(b.down_fl, b.now, down_due))
				delta = delta - 16'd1;
			if (repeat_fires(b.up_fl, b.now, up_due))
				delta = delta + 16'd1;
			side_held = b.down_fl[0] | b.up_fl[0];
		end

		// encoder button
		ev[0] = b.enc_fl[1];
		ev[1] = enc_was_pressed & ~b.enc_fl[0];
		ev[2] = b.enc_fl[0];
		enc_was_pressed = b.enc_fl[0];
		age = b.now - enc_click_ms;
		if (enc_click_pend && age > {16'd0, enc_window}) begin
			enc_click_pend = 1'b0;
			ev[3] = 1'b1;
		end
		if (b.enc_fl[2]) begin
			// a click still pending here lies within the window
			if (enc_click_pend) begin
				enc_click_pend = 1'b0;
				ev[4] = 1'b1;
			end else begin
				enc_click_pend = 1'b1;
				enc_click_ms = b.now;
			end
		end
		if (b.enc_fl[3]) begin
			ev[5] = 1'b1;
			enc_click_pend = 1'b0;
		end

		// top button
		tv[0] = b.top_fl[1];
		age = b.now - top_click_ms;
		if (top_click_pend && age > {16'd0, top_window}) begin
			top_click_pend = 1'b0;
			tv[1] = 1'b1;
		end
		if (b.top_fl[2]) begin
			if (top_ignore) begin
				top_ignore = 1'b0;
				top_click_pend = 1'b0;
			end else if (top_click_pend) begin
				top_click_pend = 1'b0;
				tv[2] = 1'b1;
			end else begin
				top_click_pend = 1'b1;
				top_click_ms = b.now;
			end
		end
		if (b.top_fl[3]) begin
			tv[3] = 1'b1;
			top_click_pend = 1'b0;
		end
		tv[4] = b.top_fl[0];

		held = b.enc_fl[0] | b.top_fl[0] | side_held;
		g.steps = delta;
		g.enc_ev = ev;
		g.top_ev = tv;
		g.held = held;
		g.touched = (delta != '0) || (ev != '0) || (tv[3:0] != '0) || held;
		return 1'b1;
	endfunction

	function automatic poll_beat_t mk_beat(input logic [1:0] o, input logic [31:0] t,
			input logic [15:0] p, input logic [3:0] ef, input logic [3:0] tf,
			input logic [1:0] df, input logic [1:0] uf);
		poll_beat_t b;
		b.op = o;
		b.now = t;
		b.pos = p;
		b.enc_fl = ef;
		b.top_fl = tf;
		b.down_fl = df;
		b.up_fl = uf;
		return b;
	endfunction

	// press, hold and release of a clicking button
	function automatic logic [3:0] press_model(inout logic down, inout logic [31:0] since,
			input logic [31:0] now);
		if (!down) begin
			if ($urandom_range(0, 99) < 25) begin
				down = 1'b1;
				since = now;
				return 4'b0011;
			end
			return 4'b0000;
		end
		if ($urandom_range(0, 99) < 35) begin
			down = 1'b0;
			return (now - since > 32'd600) ? 4'b1000 : 4'b0100;
		end
		return 4'b0001;
	endfunction

	// press, hold and release of a side button
	function automatic logic [1:0] side_model(inout logic down);
		if (!down) begin
			if ($urandom_range(0, 99) < 15) begin
				down = 1'b1;
				return 2'b11;
			end
			return 2'b00;
		end
		if ($urandom_range(0, 99) < 20) begin
			down = 1'b0;
			return 2'b00;
		end
		return 2'b01;
	endfunction

	// next random beat: mostly plausible gestures, some noise
	function automatic poll_beat_t make_gesture_beat();
		poll_beat_t b;
		int         pick;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: sim_now = sim_now + $urandom_range(1, 150);
			6, 7:             sim_now = sim_now + $urandom_range(150, 700);
			8:                sim_now = sim_now + $urandom_range(700, 70000);
			default: begin
				if ($urandom_range(0, 3) == 0)
					sim_now = $urandom;
			end
		endcase
		if ($urandom_range(0, 19) == 0)
			sim_pos = 16'($urandom);
		else
			sim_pos = sim_pos + 16'($urandom_range(0, 6)) - 16'sd3;
		b.now = sim_now;
		b.pos = sim_pos;
		b.enc_fl = press_model(enc_down, enc_since, sim_now);
		b.top_fl = press_model(top_down, top_since, sim_now);
		b.down_fl = side_model(dn_down);
		b.up_fl = side_model(up_down);
		if ($urandom_range(0, 99) < 15) begin
			b.enc_fl = 4'($urandom);
			b.top_fl = 4'($urandom);
			b.down_fl = 2'($urandom);
			b.up_fl = 2'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 86)
			b.op = bgc_pkg::OP_POLL;
		else if (pick < 92)
			b.op = bgc_pkg::OP_CONSUME;
		else if (pick < 97)
			b.op = bgc_pkg::OP_CLEAR;
		else
			b.op = OP_NONE;
		return b;
	endfunction

	// send one poll beat after a random gap, predict on acceptance
	task automatic drive_beat(input poll_beat_t b);
		int       gap;
		gesture_t g;
		gap = 0;
		if (!quiet)
			while (gap < 12 && $urandom_range(0, 99) < 30)
				gap++;
		@(negedge clk);
		if (gap > 0) begin
			poll_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll_valid <= 1'b1;
		op <= b.op;
		now_ms <= b.now;
		encoder_position <= b.pos;
		encoder_flags <= b.enc_fl;
		top_flags <= b.top_fl;
		side_down_flags <= b.down_fl;
		side_up_flags <= b.up_fl;
		do @(posedge clk); while (poll_stall);
		if (forecast_gesture(b, g))
			awaited.push_back(g);
	endtask

	// let every awaited result drain and the pipeline empty
	task automatic settle();
		@(negedge clk);
		poll_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			bgc_pkg::REG_ENC_WINDOW:   enc_window = val;
			bgc_pkg::REG_TOP_WINDOW:   top_window = val;
			bgc_pkg::REG_REPEAT_DELAY: rpt_delay = val;
			bgc_pkg::REG_REPEAT_IVAL:  rpt_ival = val;
			bgc_pkg::REG_ROTARY_EN:    rotary_en = val[0];
			bgc_pkg::REG_SIDE_EN:      side_en = val[0];
			default: ;
		endcase
	endtask

	// field extremes, every op, consume and clear behaviour
	task automatic test_ops();
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd0, 16'sh7FFF,
			4'h0, 4'h0, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'hFFFF_FFFF, 16'sh8000,
			4'hF, 4'hF, 2'b11, 2'b11));
		drive_beat(mk_beat(bgc_pkg::OP_CONSUME, 32'd5, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b00));
		// top click swallowed by the ignore flag, encoder release edge
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd10, 16'sh8000,
			4'h0, 4'b0100, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_CLEAR, 32'd20, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b00));
		drive_beat(mk_beat(OP_NONE, 32'hA5A5_5A5A, 16'sh1234,
			4'hA, 4'h5, 2'b10, 2'b01));
	endtask

	// single, double, expired and long-cancelled clicks
	task automatic test_clicks();
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd1000, 16'sh8000,
			4'b0100, 4'b0100, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd1100, 16'sh8000,
			4'b0100, 4'b0000, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd1400, 16'sh8000,
			4'b0000, 4'b0100, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd2000, 16'sh8000,
			4'b0000, 4'b0000, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd3000, 16'sh8000,
			4'b0100, 4'b0000, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd3100, 16'sh8000,
			4'b1000, 4'b1000, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd4000, 16'sh8000,
			4'b0000, 4'b0000, 2'b00, 2'b00));
	endtask

	// edge without pressed bit, repeat, release, due wrapping to idle
	task automatic test_side_repeat();
		settle();
		write_reg(bgc_pkg::REG_SIDE_EN, 16'd1);
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd100, 16'sh8000,
			4'h0, 4'h0, 2'b10, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd600, 16'sh8000,
			4'h0, 4'h0, 2'b01, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd650, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'hFFFF_FE70, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b11));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'h0000_0010, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b01));
	endtask

	// zero delays repeat on every held poll
	task automatic test_zero_delays();
		settle();
		write_reg(bgc_pkg::REG_REPEAT_DELAY, 16'd0);
		write_reg(bgc_pkg::REG_REPEAT_IVAL, 16'd0);
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd5000, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b11));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd5000, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b01));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd5001, 16'sh8000,
			4'h0, 4'h0, 2'b00, 2'b01));
	endtask

	// position ignored with the encoder switched off
	task automatic test_rotary_off();
		settle();
		write_reg(bgc_pkg::REG_ROTARY_EN, 16'd0);
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd6000, 16'sd123,
			4'h0, 4'h0, 2'b00, 2'b00));
		drive_beat(mk_beat(bgc_pkg::OP_POLL, 32'd6001, -16'sd5,
			4'h0, 4'h0, 2'b11, 2'b00));
	endtask

	task automatic run_phase(input logic [15:0] enc_win, input logic [15:0] top_win,
			input logic [15:0] delay, input logic [15:0] ival, input logic rot,
			input logic side, input logic [31:0] start_ms);
		int unsigned sent;
		poll_beat_t  b;
		settle();
		write_reg(bgc_pkg::REG_ENC_WINDOW, enc_win);
		write_reg(bgc_pkg::REG_TOP_WINDOW, top_win);
		write_reg(bgc_pkg::REG_REPEAT_DELAY, delay);
		write_reg(bgc_pkg::REG_REPEAT_IVAL, ival);
		write_reg(bgc_pkg::REG_ROTARY_EN, {15'd0, rot});
		write_reg(bgc_pkg::REG_SIDE_EN, {15'd0, side});
		sim_now = start_ms;
		sent = 0;
		while (sent < PHASE_BEATS) begin
			// a stretch with no gaps on either side
			quiet = (sent >= PHASE_BEATS / 3) && (sent < PHASE_BEATS / 3 + 60);
			b = make_gesture_beat();
			drive_beat(b);
			if (b.op != OP_NONE)
				sent++;
		end
		quiet = 1'b0;
	endtask

	task automatic test_random();
		run_phase(16'd300, 16'd300, 16'd400, 16'd100, 1'b1, 1'b1, 32'd0);
		run_phase(16'd0, 16'd0, 16'd1, 16'd1, 1'b1, 1'b1, 32'hFFFF_F000);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, $urandom);
		repeat (3)
			run_phase(16'($urandom_range(0, 1000)), 16'($urandom),
				16'($urandom_range(1, 2000)), 16'($urandom_range(1, 500)),
				1'($urandom), 1'($urandom), $urandom);
	endtask

	// receiver stall
	always @(negedge clk)
		res_stall <= !quiet && ($urandom_range(0, 99) < 30);

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		gesture_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited.size() == 0) begin
				$error("result beat with no prediction waiting");
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (steps !== want.steps) begin
					$error("steps: expected %0d, got %0d", want.steps, steps);
					mismatches++;
				end
				if (encoder_events !== want.enc_ev) begin
					$error("encoder_events: expected %b, got %b", want.enc_ev, encoder_events);
					mismatches++;
				end
				if (top_events !== want.top_ev) begin
					$error("top_events: expected %b, got %b", want.top_ev, top_events);
					mismatches++;
				end
				if (any_held !== want.held) begin
					$error("any_held: expected %b, got %b", want.held, any_held);
					mismatches++;
				end
				if (touched !== want.touched) begin
					$error("touched: expected %b, got %b", want.touched, touched);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		poll_valid = 1'b0;
		res_stall = 1'b0;
		op = bgc_pkg::OP_POLL;
		now_ms = '0;
		encoder_position = '0;
		encoder_flags = '0;
		top_flags = '0;
		side_down_flags = '0;
		side_up_flags = '0;
		quiet = 1'b0;
		mismatches = 0;

		// predictor at its reset state
		enc_window = bgc_pkg::ENC_WINDOW_RST;
		top_window = bgc_pkg::TOP_WINDOW_RST;
		rpt_delay = bgc_pkg::REPEAT_DELAY_RST;
		rpt_ival = bgc_pkg::REPEAT_IVAL_RST;
		rotary_en = bgc_pkg::ROTARY_EN_RST;
		side_en = bgc_pkg::SIDE_EN_RST;
		last_pos = '0;
		enc_was_pressed = 1'b0;
		enc_click_pend = 1'b0;
		top_click_pend = 1'b0;
		top_ignore = 1'b0;
		enc_click_ms = '0;
		top_click_ms = '0;
		down_due = '0;
		up_due = '0;

		sim_now = '0;
		sim_pos = '0;
		enc_down = 1'b0;
		top_down = 1'b0;
		dn_down = 1'b0;
		up_down = 1'b0;
		enc_since = '0;
		top_since = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_ops();
		test_clicks();
		test_side_repeat();
		test_zero_delays();
		test_rotary_off();
		test_random();

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
